// ----- rtl/doae_pkg.sv -----
// Shared types and constants for the door open alarm escalation block.
// No dependencies; every other rtl file imports this package.
package doae_pkg;

    localparam int DOORS = 2;

    localparam int SEC_W        = 8;
    localparam int ELAPSED_W    = 32;
    localparam int LOCAL_MS_W   = 18;   // 255 * 1000 fits
    localparam int CENTRAL_MS_W = 19;   // 510 * 1000 fits

    localparam logic [9:0] MS_PER_SEC = 10'd1000;

    localparam logic [SEC_W-1:0] LOCAL_SEC_RST  = 8'd10;
    localparam logic [SEC_W-1:0] GLOBAL_SEC_RST = 8'd30;

    localparam logic [0:0] CFG_LOCAL  = 1'b0;
    localparam logic [0:0] CFG_GLOBAL = 1'b1;

    typedef enum logic [2:0] {
        REQ_TICK   = 3'd0,
        REQ_LOCK   = 3'd1,
        REQ_UNLOCK = 3'd2,
        REQ_SET    = 3'd3,
        REQ_START  = 3'd4,
        REQ_STOP   = 3'd5
    } t_req;

    // per-door command, already qualified by the input handshake
    typedef struct packed {
        logic             tick;
        logic             closed;
        logic             lock;
        logic             unlock;
        logic             set_local;
        logic             set_global;
        logic             start;
        logic             stop;
        logic [SEC_W-1:0] thr;
    } t_lane_cmd;

    typedef struct packed {
        logic             local_we;
        logic             global_we;
        logic [SEC_W-1:0] data;
    } t_cfg_wr;

    // door state after the current word, plus the raise flag for it
    typedef struct packed {
        logic closed_led;
        logic local_alarm;
        logic locked;
        logic central_alarm;
        logic raised;
    } t_lane_stat;

endpackage

// ----- rtl/doae_lane.sv -----
// One door lane: open timer, thresholds, alarm and lock state.
// Depends on doae_pkg.
module doae_lane (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  doae_pkg::t_lane_cmd    i_cmd,
    input  doae_pkg::t_cfg_wr      i_cfg,
    output doae_pkg::t_lane_stat   o_stat
);
    import doae_pkg::*;

    logic                    r_open, n_open;
    logic [ELAPSED_W-1:0]    r_elapsed, n_elapsed;
    logic                    r_local_alarm, n_local_alarm;
    logic                    r_central, n_central;
    logic                    r_locked, n_locked;
    logic                    r_closed_led, n_closed_led;
    logic [SEC_W-1:0]        r_local_s, n_local_s;
    logic [SEC_W-1:0]        r_global_s, n_global_s;
    logic [LOCAL_MS_W-1:0]   local_ms;
    logic [CENTRAL_MS_W-1:0] central_ms;
    logic                    raised;

    always_comb begin
        local_ms   = LOCAL_MS_W'(r_local_s) * LOCAL_MS_W'(MS_PER_SEC);
        central_ms = (CENTRAL_MS_W'(r_local_s) + CENTRAL_MS_W'(r_global_s))
                     * CENTRAL_MS_W'(MS_PER_SEC);

        n_open        = r_open;
        n_elapsed     = r_elapsed;
        n_local_alarm = r_local_alarm;
        n_central     = r_central;
        n_locked      = r_locked;
        n_closed_led  = r_closed_led;
        n_local_s     = r_local_s;
        n_global_s    = r_global_s;
        raised        = 1'b0;

        if (i_cfg.local_we) begin
            n_local_s = i_cfg.data;
        end
        if (i_cfg.global_we) begin
            n_global_s = i_cfg.data;
        end

        if (i_cmd.tick) begin
            if (!i_cmd.closed) begin
                n_open = 1'b1;
                // elapsed tracks now - open time; counter advances before sampling
                if (!r_open) begin
                    n_elapsed    = '0;
                    n_closed_led = 1'b0;
                end else begin
                    n_elapsed = r_elapsed + ELAPSED_W'(1);
                end
                if (n_elapsed >= ELAPSED_W'(central_ms)) begin
                    n_central = 1'b1;
                    raised    = 1'b1;
                end else if (n_elapsed >= ELAPSED_W'(local_ms)) begin
                    n_local_alarm = 1'b1;
                end
            end else begin
                n_open        = 1'b0;
                n_elapsed     = '0;
                n_local_alarm = 1'b0;
                n_closed_led  = 1'b1;
            end
        end
        if (i_cmd.lock) begin
            n_locked = 1'b1;
        end
        if (i_cmd.unlock) begin
            n_locked = 1'b0;
        end
        if (i_cmd.set_local) begin
            n_local_s = i_cmd.thr;
        end
        if (i_cmd.set_global) begin
            n_global_s = i_cmd.thr;
        end
        if (i_cmd.start) begin
            n_central = 1'b1;
            raised    = 1'b1;
        end
        if (i_cmd.stop) begin
            n_central = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_open        <= 1'b0;
            r_elapsed     <= '0;
            r_local_alarm <= 1'b0;
            r_central     <= 1'b0;
            r_locked      <= 1'b0;
            r_closed_led  <= 1'b0;
            r_local_s     <= LOCAL_SEC_RST;
            r_global_s    <= GLOBAL_SEC_RST;
        end else begin
            r_open        <= n_open;
            r_elapsed     <= n_elapsed;
            r_local_alarm <= n_local_alarm;
            r_central     <= n_central;
            r_locked      <= n_locked;
            r_closed_led  <= n_closed_led;
            r_local_s     <= n_local_s;
            r_global_s    <= n_global_s;
        end
    end

    assign o_stat.closed_led    = n_closed_led;
    assign o_stat.local_alarm   = n_local_alarm;
    assign o_stat.locked        = n_locked;
    assign o_stat.central_alarm = n_central;
    assign o_stat.raised        = raised;

endmodule

// ----- rtl/doae_merge.sv -----
// Merge stage: gathers lane status into result vectors and holds the
// result word in an output register. Depends on doae_pkg.
module doae_merge (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_accept,
    input  doae_pkg::t_lane_stat [doae_pkg::DOORS-1:0] i_stat,
    input  logic                                   i_out_ready,
    output logic                                   o_out_valid,
    output logic [doae_pkg::DOORS-1:0]             o_closed_leds,
    output logic [doae_pkg::DOORS-1:0]             o_local_alarm_leds,
    output logic [doae_pkg::DOORS-1:0]             o_locked_leds,
    output logic [doae_pkg::DOORS-1:0]             o_central_alarms,
    output logic                                   o_alarm_sent
);
    import doae_pkg::*;

    logic             r_valid;
    logic [DOORS-1:0] r_closed, n_closed;
    logic [DOORS-1:0] r_local, n_local;
    logic [DOORS-1:0] r_locked, n_locked;
    logic [DOORS-1:0] r_central, n_central;
    logic             r_send, n_send;

    always_comb begin
        n_send = 1'b0;
        for (int d = 0; d < DOORS; d++) begin
            n_closed[d]  = i_stat[d].closed_led;
            n_local[d]   = i_stat[d].local_alarm;
            n_locked[d]  = i_stat[d].locked;
            n_central[d] = i_stat[d].central_alarm;
            n_send       = n_send | i_stat[d].raised;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_accept) begin
            r_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_accept) begin
            r_closed  <= n_closed;
            r_local   <= n_local;
            r_locked  <= n_locked;
            r_central <= n_central;
            r_send    <= n_send;
        end
    end

    assign o_out_valid        = r_valid;
    assign o_closed_leds      = r_closed;
    assign o_local_alarm_leds = r_local;
    assign o_locked_leds      = r_locked;
    assign o_central_alarms   = r_central;
    assign o_alarm_sent       = r_send;

endmodule

// ----- rtl/door_open_alarm_escalation.sv -----
// Top level of the door open alarm escalation block: request decode,
// one lane per door and the merge/output stage. Depends on doae_pkg,
// doae_lane and doae_merge.
//
// Takes one request word per clock and returns its result word in the next
// cycle through a registered output; a new word is taken whenever the
// output register is empty or being drained. Each door lane updates its
// 32-bit open timer and compares it with its thresholds (seconds times
// 1000) in that same cycle. No clearing pass after reset. Threshold
// register writes load the new value into every door at once.
module door_open_alarm_escalation (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic [2:0]                    i_req_type,
    input  logic [0:0]                    i_door_index,
    input  logic [doae_pkg::DOORS-1:0]    i_switch_closed,
    input  logic [doae_pkg::SEC_W-1:0]    i_threshold_seconds,
    input  logic                          i_set_local,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic [doae_pkg::DOORS-1:0]    o_closed_leds,
    output logic [doae_pkg::DOORS-1:0]    o_local_alarm_leds,
    output logic [doae_pkg::DOORS-1:0]    o_locked_leds,
    output logic [doae_pkg::DOORS-1:0]    o_central_alarms,
    output logic                          o_alarm_sent,
    input  logic                          i_cfg_we,
    input  logic [0:0]                    i_cfg_index,
    input  logic [doae_pkg::SEC_W-1:0]    i_cfg_data
);
    import doae_pkg::*;

    logic                    accept;
    logic                    is_tick, is_lock, is_unlock, is_set, is_start, is_stop;
    t_cfg_wr                 cfg;
    t_lane_cmd [DOORS-1:0]   cmd;
    t_lane_stat [DOORS-1:0]  stat;

    assign o_in_ready = !o_out_valid || i_out_ready;
    assign accept     = i_in_valid && o_in_ready;

    always_comb begin
        is_tick   = 1'b0;
        is_lock   = 1'b0;
        is_unlock = 1'b0;
        is_set    = 1'b0;
        is_start  = 1'b0;
        is_stop   = 1'b0;
        case (i_req_type)
            REQ_TICK:   is_tick   = accept;
            REQ_LOCK:   is_lock   = accept;
            REQ_UNLOCK: is_unlock = accept;
            REQ_SET:    is_set    = accept;
            REQ_START:  is_start  = accept;
            REQ_STOP:   is_stop   = accept;
            default:    ;   // unused codes change nothing
        endcase
    end

    assign cfg.local_we  = i_cfg_we && (i_cfg_index == CFG_LOCAL);
    assign cfg.global_we = i_cfg_we && (i_cfg_index == CFG_GLOBAL);
    assign cfg.data      = i_cfg_data;

    for (genvar d = 0; d < DOORS; d++) begin : g_lane
        logic sel;
        assign sel = (32'(i_door_index) == d);

        assign cmd[d].tick       = is_tick;
        assign cmd[d].closed     = i_switch_closed[d];
        assign cmd[d].lock       = is_lock && sel;
        assign cmd[d].unlock     = is_unlock && sel;
        assign cmd[d].set_local  = is_set && sel && i_set_local;
        assign cmd[d].set_global = is_set && sel && !i_set_local;
        assign cmd[d].start      = is_start && sel;
        assign cmd[d].stop       = is_stop && sel;
        assign cmd[d].thr        = i_threshold_seconds;

        doae_lane u_lane (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_cmd   (cmd[d]),
            .i_cfg   (cfg),
            .o_stat  (stat[d])
        );
    end

    doae_merge u_merge (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_accept           (accept),
        .i_stat             (stat),
        .i_out_ready        (i_out_ready),
        .o_out_valid        (o_out_valid),
        .o_closed_leds      (o_closed_leds),
        .o_local_alarm_leds (o_local_alarm_leds),
        .o_locked_leds      (o_locked_leds),
        .o_central_alarms   (o_central_alarms),
        .o_alarm_sent       (o_alarm_sent)
    );

    // a raised alarm always leaves some central alarm on in the same word
    a_send_has_central: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_alarm_sent |-> (o_central_alarms != '0))
        else $error("alarm flag without any central alarm");

    // a door with its local alarm on is open, so its closed LED is off
    a_local_not_closed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> ((o_local_alarm_leds & o_closed_leds) == '0))
        else $error("local alarm on a closed door");

    // stop request clears that door's central alarm in its own result word
    a_stop_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept && (i_req_type == REQ_STOP) |=>
            !o_central_alarms[$past(i_door_index)] && !o_alarm_sent)
        else $error("stop central did not clear the alarm");

    // a word is always taken when nothing waits at the output
    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_out_valid |-> o_in_ready)
        else $error("input stalled with empty output register");

endmodule
